// File: rtl/ddr_pkg.sv
// Shared constants, register codes and lane tables for the dawn/dusk RGB ramp.
`default_nettype none
package ddr_pkg;

    localparam int unsigned TIME_W   = 17;
    localparam int unsigned LEVEL_W  = 16;
    localparam int unsigned FRAC_W   = 13;
    localparam int unsigned NUM_W    = FRAC_W + LEVEL_W;
    localparam int unsigned RECIP_SH = NUM_W;
    localparam int unsigned RECIP_W  = 18;
    localparam int unsigned LANES    = 3;
    localparam int unsigned APB_AW   = 4;
    localparam int unsigned APB_DW   = 32;

    localparam logic [TIME_W:0]    EDGE_MARGIN = 18'd60;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_DAWN  = 2'd0,
        REG_ON    = 2'd1,
        REG_OFF   = 2'd2,
        REG_DUSK  = 2'd3
    } ddr_reg_t;

    // Lane 0 is red, 1 green, 2 blue.
    function automatic logic [FRAC_W-1:0] lane_span(input int idx);
        logic [FRAC_W-1:0] s;
        begin
            case (idx)
                0:       s = 13'd5400;
                1:       s = 13'd4320;
                default: s = 13'd3240;
            endcase
            return s;
        end
    endfunction

    function automatic logic [FRAC_W-1:0] lane_lag(input int idx);
        logic [FRAC_W-1:0] l;
        begin
            case (idx)
                0:       l = 13'd0;
                1:       l = 13'd1080;
                default: l = 13'd2160;
            endcase
            return l;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/ddr_time_if.sv
// Input channel: one time-of-day sample per transfer.
`default_nettype none
interface ddr_time_if;
    import ddr_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] time_of_day;

    modport source (output valid, output time_of_day, input ready);
    modport sink   (input valid, input time_of_day, output ready);
endinterface
`default_nettype wire

// File: rtl/ddr_level_if.sv
// Output channel: main-light flag, RGB levels and dimmer strobe per transfer.
`default_nettype none
interface ddr_level_if;
    import ddr_pkg::*;

    logic               valid;
    logic               ready;
    logic               main_lights;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic               dimmer_write;

    modport source (output valid, output main_lights, output red_level, output green_level,
                    output blue_level, output dimmer_write, input ready);
    modport sink   (input valid, input main_lights, input red_level, input green_level,
                    input blue_level, input dimmer_write, output ready);
endinterface
`default_nettype wire

// File: rtl/dawn_dusk_rgb_ramp.sv
// Pipeline: five register stages (window compare, clamp, reciprocal multiply, back-multiply,
// correction into the output register).
// Throughput: one sample per cycle while the output is not stalled; each stage advances whenever
// the stage after it is empty or advancing, so bubbles close up while the output is stalled.
// Reset: rst_n clears all valid bits and the four time registers to zero.
`default_nettype none
module dawn_dusk_rgb_ramp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ddr_pkg::APB_AW-1:0]  paddr,
    input  wire logic [ddr_pkg::APB_DW-1:0]  pwdata,
    output logic      [ddr_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    ddr_time_if.sink                         time_in,
    ddr_level_if.source                      level_out
);
    import ddr_pkg::*;

    // ---------------- configuration registers
    logic [TIME_W-1:0] dawn_reg, on_reg, off_reg, dusk_reg;
    logic              cfg_wr;
    ddr_reg_t          cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = ddr_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dawn_reg <= '0;
            on_reg   <= '0;
            off_reg  <= '0;
            dusk_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_DAWN: dawn_reg <= pwdata[TIME_W-1:0];
                REG_ON:   on_reg   <= pwdata[TIME_W-1:0];
                REG_OFF:  off_reg  <= pwdata[TIME_W-1:0];
                REG_DUSK: dusk_reg <= pwdata[TIME_W-1:0];
                default:  dawn_reg <= dawn_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_DAWN: prdata = {{(APB_DW-TIME_W){1'b0}}, dawn_reg};
            REG_ON:   prdata = {{(APB_DW-TIME_W){1'b0}}, on_reg};
            REG_OFF:  prdata = {{(APB_DW-TIME_W){1'b0}}, off_reg};
            REG_DUSK: prdata = {{(APB_DW-TIME_W){1'b0}}, dusk_reg};
            default:  prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || level_out.ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign time_in.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= time_in.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ---------------- stage 1: window compare and elapsed time
    logic [TIME_W-1:0] t;
    logic              rise_win, set_win, main_next;
    logic [TIME_W-1:0] d_next;
    logic [TIME_W-1:0] d1_reg;
    logic              m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;

    assign t = time_in.time_of_day;

    always_comb
    begin
        rise_win  = (t >= dawn_reg) && ({1'b0, t} <= ({1'b0, on_reg} + EDGE_MARGIN));
        set_win   = (({1'b0, t} + EDGE_MARGIN) >= {1'b0, off_reg}) && (t <= dusk_reg);
        main_next = (t >= on_reg) && (t <= off_reg);
        // Both windows give a non-negative distance; outside them a zero distance
        // clamps every lane to zero.
        if (rise_win)
            d_next = t - dawn_reg;
        else if (set_win)
            d_next = dusk_reg - t;
        else
            d_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && time_in.valid)
        begin
            d1_reg <= d_next;
            m1_reg <= main_next;
        end
        if (rdy2 && v1_reg) m2_reg <= m1_reg;
        if (rdy3 && v2_reg) m3_reg <= m2_reg;
        if (rdy4 && v3_reg) m4_reg <= m3_reg;
        if (rdy5 && v4_reg) m5_reg <= m4_reg;
    end

    // ---------------- stages 2..5: per-lane clamp and divide by span
    logic [LEVEL_W-1:0] lvl_reg [LANES];

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        localparam logic [FRAC_W-1:0]  SPAN  = lane_span(i);
        localparam logic [FRAC_W-1:0]  LAG   = lane_lag(i);
        localparam logic [TIME_W:0]    TOP   = 18'(LAG) + 18'(SPAN);
        localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / 64'(SPAN));

        logic [FRAC_W-1:0]  frac;
        logic [NUM_W-1:0]   n_next;
        logic [NUM_W+RECIP_W-1:0] prod;
        logic [NUM_W-1:0]   qs_next, rem;
        logic [LEVEL_W-1:0] lvl_next;

        logic               z2_reg, f2_reg, z3_reg, f3_reg, z4_reg, f4_reg;
        logic [NUM_W-1:0]   n2_reg, n3_reg, n4_reg, qs4_reg;
        logic [LEVEL_W-1:0] q3_reg, q4_reg;

        assign frac    = FRAC_W'(d1_reg - TIME_W'(LAG));
        assign n_next  = {frac, {LEVEL_W{1'b0}}} - NUM_W'(frac);
        assign prod    = n2_reg * RECIP;
        assign qs_next = NUM_W'(q3_reg) * NUM_W'(SPAN);
        assign rem     = n4_reg - qs4_reg;

        always_comb
        begin
            if (z4_reg)
                lvl_next = '0;
            else if (f4_reg)
                lvl_next = FULL_LEVEL;
            else if (rem >= NUM_W'(SPAN))
                lvl_next = q4_reg + 1'b1;
            else
                lvl_next = q4_reg;
        end

        always_ff @(posedge clk)
        begin
            if (rdy2 && v1_reg)
            begin
                z2_reg <= (d1_reg <= TIME_W'(LAG));
                f2_reg <= ({1'b0, d1_reg} >= TOP);
                n2_reg <= n_next;
            end
            if (rdy3 && v2_reg)
            begin
                z3_reg <= z2_reg;
                f3_reg <= f2_reg;
                n3_reg <= n2_reg;
                // reciprocal estimate is the true quotient or one below it
                q3_reg <= prod[RECIP_SH+LEVEL_W-1:RECIP_SH];
            end
            if (rdy4 && v3_reg)
            begin
                z4_reg  <= z3_reg;
                f4_reg  <= f3_reg;
                n4_reg  <= n3_reg;
                q4_reg  <= q3_reg;
                qs4_reg <= qs_next;
            end
            if (rdy5 && v4_reg)
                lvl_reg[i] <= lvl_next;
        end
    end

    // ---------------- output register
    assign level_out.valid        = v5_reg;
    assign level_out.main_lights  = m5_reg;
    assign level_out.red_level    = lvl_reg[0];
    assign level_out.green_level  = lvl_reg[1];
    assign level_out.blue_level   = lvl_reg[2];
    assign level_out.dimmer_write = (lvl_reg[0] != '0) && (lvl_reg[0] != FULL_LEVEL);

    // ---------------- assertions
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !time_in.ready |-> (level_out.valid && !level_out.ready))
        else $error("input stalled while output path could advance");

    a_lane_order: assert property (@(posedge clk) disable iff (!rst_n)
        level_out.valid |-> (level_out.green_level <= level_out.red_level)
                         && (level_out.blue_level <= level_out.green_level))
        else $error("ramp lanes out of order");

    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !level_out.valid) |=> level_out.valid)
        else $error("stage four item did not reach output register");

endmodule
`default_nettype wire
